>>> sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int DATA_W  = 32;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// one stored line: key, value and recency rank (0 = most recent)
	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0]  rank;
	} entry_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SCAN     = 7'b0000010,
		ST_SCAN_END = 7'b0000100,
		ST_DECIDE   = 7'b0001000,
		ST_UPD      = 7'b0010000,
		ST_UPD_END  = 7'b0100000,
		ST_FIN      = 7'b1000000
	} state_t;

endpackage

>>> sv/lkvc_if.sv
// ----------------------------------------------------------------------------
// lkvc_req_if / lkvc_rsp_if
// Valid/ready channels carrying request and response words of the cache.
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;
	logic                     evicted;
	logic [CAP_W-1:0]         occupancy;

	modport source (output valid, output hit, output read_value, output evicted,
		output occupancy, input ready);
	modport sink   (input valid, input hit, input read_value, input evicted,
		input occupancy, output ready);
endinterface

>>> sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with LRU replacement, one word at a time.
// Each word: a scan of the entry memory (one read per cycle) for key match, then,
// when the key hits or a put stores it, a read-modify-write pass to age the
// recency ranks. A new word is accepted only in idle, once the previous result
// has gone to the output register. Reset clears valid bits and count, capacity
// 16; keys, values, ranks not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lkvc_req_if.sink         req,
	lkvc_rsp_if.source       rsp
);

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;

	// operation under work
	logic                op_func_q;
	logic [DATA_W-1:0]   op_key_q;
	logic [DATA_W-1:0]   op_value_q;

	// scan results
	logic                hit_found_q, lru_found_q, free_found_q;
	logic [IDX_W-1:0]    hit_idx_q, lru_idx_q, free_idx_q;
	logic [IDX_W-1:0]    hit_rank_q;
	logic [DATA_W-1:0]   hit_value_q;

	// update pass controls
	logic [IDX_W-1:0]    slot_q;
	logic [CNT_W-1:0]    lim_q;
	logic                lim_all_q;
	logic                ev_q;

	// memory read pipeline
	entry_t              entry_mem [ENTRIES];
	entry_t              rd_data_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                rd_scan_s1, rd_upd_s1;

	// output register
	logic                rsp_valid_q;
	logic                rsp_hit_q, rsp_ev_q;
	logic [DATA_W-1:0]   rsp_value_q;
	logic [CNT_W-1:0]    rsp_occ_q;

	logic [CNT_W-1:0]    eff_cap;
	logic                idx_last;
	logic                out_free;
	logic                wr_en;
	entry_t              wr_data;
	logic                is_slot;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > 32'(ENTRIES)) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	assign idx_last = (idx_q == IDX_W'(ENTRIES - 1));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	// write-back of the update pass: target slot gets rank 0, newer ones age
	assign is_slot = (rd_idx_s1 == slot_q);
	always_comb begin
		wr_data = rd_data_s1;
		if (is_slot) begin
			wr_data.rank = '0;
			if (op_func_q == FUNC_PUT) begin
				wr_data.key   = op_key_q;
				wr_data.value = op_value_q;
			end
		end else begin
			wr_data.rank = rd_data_s1.rank + IDX_W'(1);
		end
	end
	assign wr_en = rd_upd_s1 && (is_slot || (valid_q[rd_idx_s1] &&
		(lim_all_q || (CNT_W'(rd_data_s1.rank) < lim_q))));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[rd_idx_s1] <= wr_data;
		end
		rd_data_s1 <= entry_mem[idx_q];
		rd_idx_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_scan_s1 <= 1'b0;
			rd_upd_s1  <= 1'b0;
		end else begin
			rd_scan_s1 <= (state_q == ST_SCAN);
			rd_upd_s1  <= (state_q == ST_UPD);
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_W'(16);
			valid_q      <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			lim_all_q    <= 1'b0;
			ev_q         <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cap_q   <= cfg_wdata;
				valid_q <= '0;
				count_q <= '0;
			end

			// compare stage of the scan
			if (rd_scan_s1) begin
				if (!hit_found_q && valid_q[rd_idx_s1] && rd_data_s1.key == op_key_q) begin
					hit_found_q <= 1'b1;
				end
				if (!lru_found_q && valid_q[rd_idx_s1] &&
						(CNT_W'(rd_data_s1.rank) + CNT_W'(1) == count_q)) begin
					lru_found_q <= 1'b1;
				end
				if (!free_found_q && !valid_q[rd_idx_s1]) begin
					free_found_q <= 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						hit_found_q  <= 1'b0;
						lru_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						idx_q        <= '0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_last) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					idx_q     <= '0;
					lim_all_q <= 1'b0;
					ev_q      <= 1'b0;
					state_q   <= ST_FIN;
					if (hit_found_q) begin
						lim_q   <= CNT_W'(hit_rank_q);
						state_q <= ST_UPD;
					end else if (op_func_q == FUNC_PUT) begin
						if (count_q >= eff_cap) begin
							if (lru_found_q) begin
								lim_q   <= count_q;
								ev_q    <= 1'b1;
								state_q <= ST_UPD;
							end
						end else if (free_found_q) begin
							lim_all_q           <= 1'b1;
							valid_q[free_idx_q] <= 1'b1;
							count_q             <= count_q + CNT_W'(1);
							state_q             <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_last) begin
						state_q <= ST_UPD_END;
					end
				end
				ST_UPD_END: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_func_q  <= req.func;
			op_key_q   <= req.key;
			op_value_q <= req.value;
		end
		if (rd_scan_s1) begin
			if (!hit_found_q && valid_q[rd_idx_s1] && rd_data_s1.key == op_key_q) begin
				hit_idx_q   <= rd_idx_s1;
				hit_rank_q  <= rd_data_s1.rank;
				hit_value_q <= rd_data_s1.value;
			end
			if (!lru_found_q && valid_q[rd_idx_s1] &&
					(CNT_W'(rd_data_s1.rank) + CNT_W'(1) == count_q)) begin
				lru_idx_q <= rd_idx_s1;
			end
			if (!free_found_q && !valid_q[rd_idx_s1]) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			if (hit_found_q) begin
				slot_q <= hit_idx_q;
			end else if (count_q >= eff_cap) begin
				slot_q <= lru_idx_q;
			end else begin
				slot_q <= free_idx_q;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			rsp_hit_q <= hit_found_q;
			rsp_ev_q  <= ev_q;
			rsp_occ_q <= count_q;
			if (op_func_q == FUNC_PUT) begin
				rsp_value_q <= '0;
			end else if (hit_found_q) begin
				rsp_value_q <= hit_value_q;
			end else begin
				rsp_value_q <= '1;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.evicted    = rsp_ev_q;
	assign rsp.occupancy  = CAP_W'(rsp_occ_q);

endmodule
